// ----- rtl/hmm_pkg.sv -----
// Shared codes for the hash multimap engine.
// Holds request kinds and result status codes; no dependencies.
package hmm_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_LIST_FULL  = 2'd3
  } status_e;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned TotW = 8;

endpackage

// ----- rtl/hmm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hmm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/hmm_rem.sv -----
// Remainder of a 32-bit magnitude by a constant modulus, one key byte per cycle
// by reciprocal multiplication; no dependencies.
module hmm_rem #(
  parameter int unsigned MODULUS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                dividend_i,
  output logic                       done_o,
  output logic [$clog2(MODULUS)-1:0] rem_o
);

  localparam int unsigned RW = $clog2(MODULUS);
  localparam int unsigned XW = RW + 8;
  localparam int unsigned SH = XW + RW;
  localparam int unsigned PW = XW + SH + 1;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SH) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
  localparam logic [SH:0] RECIP = RECIP64[SH:0];

  logic          busy_q;
  logic          done_q;
  logic [1:0]    cnt_q;
  logic [31:0]   dvd_q;
  logic [RW-1:0] rem_q;
  logic [XW-1:0] x;
  logic [PW-1:0] prod;
  logic [7:0]    quo;
  logic [XW-1:0] qm;
  logic [XW-1:0] rx;

  // Append the next key byte and reduce by the modulus through the reciprocal
  always_comb begin
    x    = {rem_q, dvd_q[31:24]};
    prod = PW'(x) * PW'(RECIP);
    quo  = prod[SH+7:SH];
    qm   = XW'(quo * MODULUS);
    rx   = x - qm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[23:0], 8'd0};
      rem_q <= rx[RW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/hash_multimap_engine.sv -----
// Top level of the hash multimap engine: request sequencer, probe walk,
// slot and value memories. Depends on hmm_pkg, hmm_ram and hmm_rem.
//
//  channel  | dir | tdata                                         | tuser     | tlast
//  s_axis   | in  | key[31:0], value[63:32]                       | req_type  | -
//  m_axis   | out | found_value[31:0], total_values[39:32],       | status    | last
//           |     | map_empty[40], zero fill to 48                |           |
//
// A request first computes the home-slot remainder (one key byte per cycle), then probes
// by slot memory read and compare, up to TABLE_SLOTS probes.
// Remove reads and compares each value in turn, then reads and writes each value shifted down;
// search reads, latches and emits each value in turn, and waits on any output stall.
// Input is ready only while the sequencer idles. Reset clears slot occupancy
// and the value count at once; no clearing pass is needed.
module hash_multimap_engine #(
  parameter int unsigned TABLE_SLOTS    = 16,
  parameter int unsigned VALUES_PER_KEY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // found_value[31:0], total_values[39:32], map_empty[40]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned SW  = $clog2(TABLE_SLOTS);
  localparam int unsigned CW  = $clog2(VALUES_PER_KEY + 1);
  localparam int unsigned AW  = $clog2(TABLE_SLOTS * VALUES_PER_KEY);
  localparam int unsigned TW  = $clog2(TABLE_SLOTS * VALUES_PER_KEY + 1);
  localparam int unsigned TXW = (TW > 8) ? TW : 8;
  localparam int unsigned KRW = hmm_pkg::KeyW + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_PRB_RD, S_PRB_CHK, S_ADD, S_RM_RD, S_RM_CHK,
    S_SH_RD, S_SH_WR, S_RM_FIN, S_SR_RD, S_SR_DAT, S_EMIT
  } state_e;

  state_e            state_q, state_d;
  hmm_pkg::req_e     req_q, req_d;
  logic [31:0]       key_q, key_d;
  logic [31:0]       val_q, val_d;
  logic [SW-1:0]     pos_q, pos_d;
  logic [SW:0]       step_q, step_d;
  logic [SW-1:0]     inc_q, inc_d;
  logic [SW:0]       k_q, k_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     j_q, j_d;
  logic [TW-1:0]     total_q, total_d;
  logic [TABLE_SLOTS-1:0] used_q, used_d;
  hmm_pkg::status_e  rst_st_q, rst_st_d;
  logic [31:0]       rval_q, rval_d;
  logic              rlast_q, rlast_d;

  logic              ov_q;
  logic [47:0]       od_q;
  logic [1:0]        ou_q;
  logic              ol_q;

  // Remainder unit
  logic              rem_start;
  logic              rem_done;
  logic [SW-1:0]     rem_val;
  logic [31:0]       in_key;
  logic [31:0]       in_mag;

  // Memory ports
  logic              kram_we;
  logic [SW-1:0]     kram_raddr;
  logic [KRW-1:0]    kram_wdata, kram_rdata;
  logic              vram_we;
  logic [AW-1:0]     vram_waddr, vram_raddr;
  logic [31:0]       vram_wdata, vram_rdata;

  // Probe arithmetic and helpers
  logic [SW:0]       inc_sum, pos_sum;
  logic [SW-1:0]     inc_next, pos_next;
  logic [AW-1:0]     base;
  logic              out_free;
  logic [TXW-1:0]    tot_ext;
  logic [7:0]        tot_sat;
  logic [31:0]       rkey;
  logic [CW-1:0]     rcnt;

  assign in_key = s_axis_tdata[31:0];
  assign in_mag = in_key[31] ? (32'd0 - in_key) : in_key;
  assign rem_start = (state_q == S_IDLE) && s_axis_tvalid &&
                     (s_axis_tuser != hmm_pkg::REQ_NONE);

  hmm_rem #(.MODULUS(TABLE_SLOTS)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (in_mag),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  hmm_ram #(.WIDTH(KRW), .DEPTH(TABLE_SLOTS)) u_kram (
    .clk_i   (clk_i),
    .we_i    (kram_we),
    .waddr_i (pos_q),
    .wdata_i (kram_wdata),
    .raddr_i (kram_raddr),
    .rdata_o (kram_rdata)
  );

  hmm_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS * VALUES_PER_KEY)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  // Next probe offset and position, each reduced by one compare-subtract
  always_comb begin
    inc_sum  = {1'b0, inc_q} + step_q;
    inc_next = (inc_sum >= (SW+1)'(TABLE_SLOTS)) ?
               SW'(inc_sum - (SW+1)'(TABLE_SLOTS)) : SW'(inc_sum);
    pos_sum  = {1'b0, pos_q} + {1'b0, inc_next};
    pos_next = (pos_sum >= (SW+1)'(TABLE_SLOTS)) ?
               SW'(pos_sum - (SW+1)'(TABLE_SLOTS)) : SW'(pos_sum);
  end

  assign base     = AW'(pos_q * VALUES_PER_KEY);
  assign rkey     = kram_rdata[31:0];
  assign rcnt     = kram_rdata[KRW-1:32];
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign tot_ext = TXW'(total_q);
  assign tot_sat = (tot_ext > TXW'(255)) ? 8'hFF : tot_ext[7:0];

  // Sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    key_d      = key_q;
    val_d      = val_q;
    pos_d      = pos_q;
    step_d     = step_q;
    inc_d      = inc_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    j_d        = j_q;
    total_d    = total_q;
    used_d     = used_q;
    rst_st_d   = rst_st_q;
    rval_d     = rval_q;
    rlast_d    = rlast_q;
    kram_we    = 1'b0;
    kram_raddr = pos_q;
    kram_wdata = {cnt_q, key_q};
    vram_we    = 1'b0;
    vram_waddr = base + AW'(j_q);
    vram_wdata = vram_rdata;
    vram_raddr = base + AW'(j_q);

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d  = hmm_pkg::req_e'(s_axis_tuser);
          key_d  = in_key;
          val_d  = s_axis_tdata[63:32];
          // drop unknown requests without a result
          if (s_axis_tuser != hmm_pkg::REQ_NONE) begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (rem_done) begin
          pos_d   = rem_val;
          step_d  = {1'b0, rem_val} + (SW+1)'(1);
          inc_d   = '0;
          k_d     = '0;
          state_d = S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        state_d = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        if (!used_q[pos_q] || rkey == key_q) begin
          cnt_d = used_q[pos_q] ? rcnt : '0;
          j_d   = '0;
          case (req_q)
            hmm_pkg::REQ_ADD: state_d = S_ADD;
            hmm_pkg::REQ_REMOVE: begin
              if (!used_q[pos_q] || rcnt == '0) begin
                rst_st_d = hmm_pkg::ST_NOT_FOUND;
                rval_d   = '0;
                rlast_d  = 1'b1;
                state_d  = S_EMIT;
              end else begin
                state_d = S_RM_RD;
              end
            end
            default: begin
              if (!used_q[pos_q] || rcnt == '0) begin
                rst_st_d = hmm_pkg::ST_NOT_FOUND;
                rval_d   = '0;
                rlast_d  = 1'b1;
                state_d  = S_EMIT;
              end else begin
                state_d = S_SR_RD;
              end
            end
          endcase
        end else if (k_q + (SW+1)'(1) == (SW+1)'(TABLE_SLOTS)) begin
          rst_st_d = (req_q == hmm_pkg::REQ_ADD) ? hmm_pkg::ST_TABLE_FULL
                                                 : hmm_pkg::ST_NOT_FOUND;
          rval_d   = '0;
          rlast_d  = 1'b1;
          state_d  = S_EMIT;
        end else begin
          k_d     = k_q + (SW+1)'(1);
          inc_d   = inc_next;
          pos_d   = pos_next;
          state_d = S_PRB_RD;
        end
      end
      S_ADD: begin
        rval_d  = '0;
        rlast_d = 1'b1;
        state_d = S_EMIT;
        if (cnt_q >= CW'(VALUES_PER_KEY)) begin
          rst_st_d = hmm_pkg::ST_LIST_FULL;
        end else begin
          rst_st_d       = hmm_pkg::ST_OK;
          vram_we        = 1'b1;
          vram_waddr     = base + AW'(cnt_q);
          vram_wdata     = val_q;
          kram_we        = 1'b1;
          kram_wdata     = {cnt_q + CW'(1), key_q};
          used_d[pos_q]  = 1'b1;
          total_d        = total_q + TW'(1);
        end
      end
      S_RM_RD: begin
        state_d = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (vram_rdata == val_q) begin
          state_d = ({1'b0, j_q} + (CW+1)'(1) < {1'b0, cnt_q}) ? S_SH_RD : S_RM_FIN;
        end else if ({1'b0, j_q} + (CW+1)'(1) == {1'b0, cnt_q}) begin
          rst_st_d = hmm_pkg::ST_NOT_FOUND;
          rval_d   = '0;
          rlast_d  = 1'b1;
          state_d  = S_EMIT;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_RM_RD;
        end
      end
      S_SH_RD: begin
        // read the value above the hole
        vram_raddr = base + AW'(j_q) + AW'(1);
        state_d    = S_SH_WR;
      end
      S_SH_WR: begin
        vram_we = 1'b1;
        j_d     = j_q + CW'(1);
        state_d = ({1'b0, j_q} + (CW+1)'(2) < {1'b0, cnt_q}) ? S_SH_RD : S_RM_FIN;
      end
      S_RM_FIN: begin
        kram_we    = 1'b1;
        kram_wdata = {cnt_q - CW'(1), key_q};
        total_d    = total_q - TW'(1);
        rst_st_d   = hmm_pkg::ST_OK;
        rval_d     = '0;
        rlast_d    = 1'b1;
        state_d    = S_EMIT;
      end
      S_SR_RD: begin
        state_d = S_SR_DAT;
      end
      S_SR_DAT: begin
        rst_st_d = hmm_pkg::ST_OK;
        rval_d   = vram_rdata;
        rlast_d  = ({1'b0, j_q} + (CW+1)'(1) == {1'b0, cnt_q});
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (rlast_q) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + CW'(1);
            state_d = S_SR_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, occupancy, count and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      total_q <= '0;
      ov_q    <= 1'b0;
      od_q    <= '0;
      ou_q    <= '0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      total_q <= total_d;
      if (state_q == S_EMIT && out_free) begin
        ov_q <= 1'b1;
        od_q <= {7'd0, (total_q == '0), tot_sat, rval_q};
        ou_q <= rst_st_q;
        ol_q <= rlast_q;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    key_q    <= key_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    step_q   <= step_d;
    inc_q    <= inc_d;
    k_q      <= k_d;
    cnt_q    <= cnt_d;
    j_q      <= j_d;
    rst_st_q <= rst_st_d;
    rval_q   <= rval_d;
    rlast_q  <= rlast_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for hash_multimap_engine: directed and random add, remove and
// search requests, checked against an in-bench model of the table. Depends on hmm_pkg and hash_multimap_engine.
`timescale 1ns / 1ps

module testbench;

  localparam int Slots    = 16;
  localparam int PerKey   = 8;
  localparam int StallMax = 20000;

  typedef struct packed {
    hmm_pkg::status_e status;
    logic [31:0]      found_value;
    logic             last;
    logic [7:0]       total_values;
    logic             map_empty;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // key[31:0], value[63:32]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // found_value[31:0], total_values[39:32], map_empty[40]
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        m_axis_tlast;

  // model of the table
  logic        mdl_used [Slots];
  logic [31:0] mdl_key [Slots];
  int          mdl_cnt [Slots];
  logic [31:0] mdl_vals [Slots][PerKey];
  int          mdl_total;

  result_t expected_results[$];
  int      fail_count = 0;
  int      idle_cycles = 0;
  bit      hold_sink = 1'b0;
  bit      sink_busy = 1'b1;
  logic [31:0] key_pool [8];

  hash_multimap_engine dut (.*);

  initial forever #5 clk_i = ~clk_i;

  function automatic void push_result(hmm_pkg::status_e st, logic [31:0] v, logic l);
    result_t r;
    r.status       = st;
    r.found_value  = v;
    r.last         = l;
    r.total_values = (mdl_total > 255) ? 8'd255 : mdl_total[7:0];
    r.map_empty    = (mdl_total == 0);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic int lookup_slot(logic [31:0] key);
    for (int i = 0; i < Slots; i++)
      if (mdl_used[i] && mdl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic hmm_pkg::status_e model_add(logic [31:0] key, logic [31:0] v);
    logic [31:0] mag;
    int unsigned pos, step, k;
    mag  = key[31] ? -key : key;
    pos  = mag % Slots;
    step = pos + 1;
    k    = 0;
    while (mdl_used[pos] && mdl_key[pos] != key) begin
      k++;
      if (k >= Slots) return hmm_pkg::ST_TABLE_FULL;
      pos = (pos + k * step) % Slots;
    end
    if (!mdl_used[pos]) begin
      mdl_used[pos] = 1'b1;
      mdl_key[pos]  = key;
      mdl_cnt[pos]  = 0;
    end
    if (mdl_cnt[pos] >= PerKey) return hmm_pkg::ST_LIST_FULL;
    mdl_vals[pos][mdl_cnt[pos]] = v;
    mdl_cnt[pos]++;
    mdl_total++;
    return hmm_pkg::ST_OK;
  endfunction

  function automatic hmm_pkg::status_e model_remove(logic [31:0] key, logic [31:0] v);
    int s;
    s = lookup_slot(key);
    if (s < 0) return hmm_pkg::ST_NOT_FOUND;
    for (int j = 0; j < mdl_cnt[s]; j++)
      if (mdl_vals[s][j] == v) begin
        for (int m = j + 1; m < mdl_cnt[s]; m++) mdl_vals[s][m-1] = mdl_vals[s][m];
        mdl_cnt[s]--;
        mdl_total--;
        return hmm_pkg::ST_OK;
      end
    return hmm_pkg::ST_NOT_FOUND;
  endfunction

  // work out the results one request causes
  function automatic void predict_request(hmm_pkg::req_e req, logic [31:0] key,
                                          logic [31:0] v);
    int s;
    case (req)
      hmm_pkg::REQ_ADD: begin
        hmm_pkg::status_e st;
        st = model_add(key, v);
        push_result(st, '0, 1'b1);
      end
      hmm_pkg::REQ_REMOVE: begin
        hmm_pkg::status_e st;
        st = model_remove(key, v);
        push_result(st, '0, 1'b1);
      end
      hmm_pkg::REQ_SEARCH: begin
        s = lookup_slot(key);
        if (s < 0 || mdl_cnt[s] == 0) push_result(hmm_pkg::ST_NOT_FOUND, '0, 1'b1);
        else
          for (int j = 0; j < mdl_cnt[s]; j++)
            push_result(hmm_pkg::ST_OK, mdl_vals[s][j], j == mdl_cnt[s] - 1);
      end
      default: ;
    endcase
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(hmm_pkg::req_e req, logic [31:0] key, logic [31:0] v,
                              bit gaps = 1);
    int gap;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {v, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(req, key, v);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // extremes, all request kinds, misses and the unknown request
  task automatic test_directed();
    send_request(hmm_pkg::REQ_SEARCH, 32'h8000_0000, '0);
    send_request(hmm_pkg::REQ_REMOVE, 32'd5, 32'd1);
    send_request(hmm_pkg::REQ_ADD, 32'h8000_0000, 32'h7fff_ffff);
    send_request(hmm_pkg::REQ_ADD, 32'h7fff_ffff, 32'h8000_0000);
    send_request(hmm_pkg::REQ_ADD, 32'hffff_ffff, 32'hffff_ffff);
    send_request(hmm_pkg::REQ_ADD, 32'd0, 32'd0);
    send_request(hmm_pkg::REQ_ADD, 32'd0, 32'd0);
    send_request(hmm_pkg::REQ_NONE, 32'd0, 32'd0);
    send_request(hmm_pkg::REQ_SEARCH, 32'd0, 32'hffff_ffff);
    send_request(hmm_pkg::REQ_REMOVE, 32'd0, 32'd9);
    send_request(hmm_pkg::REQ_REMOVE, 32'd0, 32'd0);
    send_request(hmm_pkg::REQ_REMOVE, 32'd0, 32'd0);
    send_request(hmm_pkg::REQ_SEARCH, 32'd0, '0);
    send_request(hmm_pkg::REQ_SEARCH, 32'h8000_0000, '0);
    send_request(hmm_pkg::REQ_SEARCH, 32'hffff_ffff, '0);
    drain_results();
  endtask

  // overfill one key's list, search all of it, remove one value and search again
  task automatic test_list_full();
    for (int i = 0; i < PerKey + 2; i++)
      send_request(hmm_pkg::REQ_ADD, 32'h1234_5678, $urandom());
    send_request(hmm_pkg::REQ_SEARCH, 32'h1234_5678, '0);
    send_request(hmm_pkg::REQ_REMOVE, 32'h1234_5678,
                 mdl_vals[lookup_slot(32'h1234_5678)][3]);
    send_request(hmm_pkg::REQ_SEARCH, 32'h1234_5678, '0);
    drain_results();
  endtask

  // add more distinct keys than there are slots, so the later adds report a full table
  task automatic test_table_full();
    for (int i = 0; i < Slots + 6; i++)
      send_request(hmm_pkg::REQ_ADD, 32'h0100_0000 + i * 32'h1_0001, $urandom());
    drain_results();
  endtask

  // keys come mostly from a small pool so adds, removes and searches meet each other
  task automatic test_random(int n);
    logic [31:0] key, v;
    int s, pick;
    hmm_pkg::req_e req;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      key  = (pick < 8) ? key_pool[$urandom_range(0, 7)] : $urandom();
      pick = $urandom_range(0, 9);
      if (pick < 4) req = hmm_pkg::REQ_ADD;
      else if (pick < 7) req = hmm_pkg::REQ_REMOVE;
      else if (pick < 9) req = hmm_pkg::REQ_SEARCH;
      else req = hmm_pkg::REQ_NONE;
      v    = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 7);
      s    = lookup_slot(key);
      if (req == hmm_pkg::REQ_REMOVE && s >= 0 && mdl_cnt[s] > 0 && $urandom_range(0, 2) != 0)
        v = mdl_vals[s][$urandom_range(0, mdl_cnt[s] - 1)];
      send_request(req, key, v);
    end
  endtask

  // hold the sink off while requests keep coming, then let it drain
  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int i = 0; i < 12; i++) send_request(hmm_pkg::REQ_SEARCH, key_pool[i % 8], '0, 0);
    drain_results();
  endtask

  // result side: random stalls, with one long hold when asked
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (!sink_busy && $urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no expectation pending");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tuser != e.status) begin
          $error("status: expected %0d actual %0d", e.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[31:0] != e.found_value) begin
          $error("found_value: expected %0h actual %0h", e.found_value, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tlast != e.last) begin
          $error("last: expected %0d actual %0d", e.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tdata[39:32] != e.total_values) begin
          $error("total_values: expected %0d actual %0d", e.total_values, m_axis_tdata[39:32]);
          fail_count++;
        end
        if (m_axis_tdata[40] != e.map_empty) begin
          $error("map_empty: expected %0d actual %0d", e.map_empty, m_axis_tdata[40]);
          fail_count++;
        end
      end
    end
  end

  // count cycles with no handshake on either side; fail once the count passes StallMax
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallMax) begin
      $display("hash_multimap_engine test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      mdl_used[i] = 1'b0;
      mdl_cnt[i]  = 0;
    end
    mdl_total = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = (i < 2) ? $urandom() : $urandom_range(0, 40) - 20;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_list_full();
    test_table_full();
    // empty the table again through removes is not possible; keys persist, so restart pool use
    test_random(200);
    test_backpressure();
    sink_busy = 1'b0;
    test_random(230);
    drain_results();
    if (fail_count == 0 && expected_results.size() == 0)
      $display("hash_multimap_engine test passed");
    else
      $display("hash_multimap_engine test failed");
    $finish;
  end

endmodule

// ----- hash_multimap_engine.f -----
rtl/hmm_pkg.sv
rtl/hmm_ram.sv
rtl/hmm_rem.sv
rtl/hash_multimap_engine.sv
tb/testbench.sv
